// ===== hdl/char_histogram_scaled_bars_defines.svh =====
// assertion macros shared by the histogram block
`ifndef CHAR_HISTOGRAM_SCALED_BARS_DEFINES_SVH
`define CHAR_HISTOGRAM_SCALED_BARS_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define CHSB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define CHSB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/chsb_pkg.sv =====
// package: sizes, payload types, fsm states and control structs of the histogram block
package chsb_pkg;

  localparam int unsigned NUM_BINS   = 128;
  localparam int unsigned COUNT_BITS = 24;
  localparam int unsigned IDX_W      = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned SCALE_W    = 8;
  localparam int unsigned FIELD_W    = 24;
  localparam int unsigned BAR_W      = 8;
  localparam int unsigned PROD_W     = COUNT_BITS + SCALE_W;
  localparam int unsigned STEP_W     = $clog2(BAR_W);

  localparam logic [SCALE_W-1:0]    SCALE_RESET = SCALE_W'(20);
  localparam logic [COUNT_BITS-1:0] MAX_RESET   = COUNT_BITS'(1);

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e              command;
    logic [CODE_W-1:0] code;
  } req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] bin_count;
    logic [BAR_W-1:0]   bar_length;
    logic [FIELD_W-1:0] largest_count;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_PREP,
    ST_DIV
  } state_e;

  typedef struct packed {
    logic lookup;    // capture request, read bin
    logic update;    // write incremented bin, track max
    logic scale;     // count times bar scale
    logic div_init;  // load divider from product
    logic div_step;  // one quotient bit
    logic finish;    // last quotient bit, raise result strobe
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_query;
  } ctrl_sts_t;

  // low field bits of a counter, zero extended when the counter is narrower
  function automatic logic [FIELD_W-1:0] to_field(input logic [COUNT_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[FIELD_W-1:0];
  endfunction

endpackage

// ===== hdl/chsb_ctrl.sv =====
// controller: sequences lookup, update, scaling and the bit-serial divide
module chsb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  chsb_pkg::ctrl_sts_t sts_i,
  output chsb_pkg::ctrl_cmd_t cmd_o
);

  chsb_pkg::state_e               state_q, state_d;
  logic [chsb_pkg::STEP_W-1:0]    cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chsb_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      chsb_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.lookup = 1'b1;
          state_d      = chsb_pkg::ST_READ;
        end
      end
      chsb_pkg::ST_READ: begin
        if (sts_i.is_query) begin
          cmd_o.scale = 1'b1;
          state_d     = chsb_pkg::ST_PREP;
        end else begin
          cmd_o.update = 1'b1;
          state_d      = chsb_pkg::ST_IDLE;
        end
      end
      chsb_pkg::ST_PREP: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = chsb_pkg::ST_DIV;
      end
      chsb_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = chsb_pkg::STEP_W'(cnt_q + 1'b1);
        if (cnt_q == chsb_pkg::STEP_W'(chsb_pkg::BAR_W - 1)) begin
          cmd_o.finish = 1'b1;
          state_d      = chsb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = chsb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/chsb_dp.sv =====
// datapath: bin memory, running max, scale register, multiplier and divider
`include "char_histogram_scaled_bars_defines.svh"

module chsb_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  chsb_pkg::req_t                     req_i,
  input  logic                               cfg_we_i,
  input  logic [chsb_pkg::SCALE_W-1:0]       cfg_wdata_i,
  input  chsb_pkg::ctrl_cmd_t                cmd_i,
  output chsb_pkg::ctrl_sts_t                sts_o,
  output logic                               valid_o,
  output chsb_pkg::rsp_t                     rsp_o
);

  localparam int unsigned CW = chsb_pkg::COUNT_BITS;
  localparam int unsigned BW = chsb_pkg::BAR_W;

  logic [CW-1:0]                 mem [chsb_pkg::NUM_BINS];
  logic [chsb_pkg::NUM_BINS-1:0] vld_q;
  logic [chsb_pkg::SCALE_W-1:0]  scale_q;
  logic [CW-1:0]                 max_q;
  logic                          valid_q;

  chsb_pkg::cmd_e                op_q;
  logic                          inside_q;
  logic [chsb_pkg::IDX_W-1:0]    idx_q;
  logic [CW-1:0]                 rd_q;
  logic                          rdv_q;
  logic [CW-1:0]                 count_q;
  logic [chsb_pkg::PROD_W-1:0]   prod_q;
  logic [CW-1:0]                 rem_q;
  logic [BW-1:0]                 lo_q;
  logic [BW-1:0]                 quo_q;

  logic                          in_range_w;
  logic [chsb_pkg::IDX_W-1:0]    rd_addr_w;
  logic [CW-1:0]                 cur_w;
  logic [CW-1:0]                 inc_w;
  logic [CW:0]                   trial_w;
  logic [CW:0]                   diff_w;
  logic                          ge_w;
  logic [CW-1:0]                 rem_d;

  assign in_range_w = ({1'b0, req_i.code} < (chsb_pkg::CODE_W + 1)'(chsb_pkg::NUM_BINS));
  assign rd_addr_w  = in_range_w ? req_i.code[chsb_pkg::IDX_W-1:0] : '0;

  // bin never written reads as zero; codes past the top bin read as zero
  assign cur_w = (inside_q && rdv_q) ? rd_q : '0;
  assign inc_w = (cur_w == '1) ? cur_w : CW'(cur_w + 1'b1);

  // restoring divide, one quotient bit per step
  assign trial_w = {rem_q, lo_q[BW-1]};
  assign ge_w    = (trial_w >= {1'b0, max_q});
  assign diff_w  = trial_w - {1'b0, max_q};
  assign rem_d   = ge_w ? diff_w[CW-1:0] : trial_w[CW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      scale_q <= chsb_pkg::SCALE_RESET;
      max_q   <= chsb_pkg::MAX_RESET;
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.finish;
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
      if (cmd_i.update && inside_q) begin
        vld_q[idx_q] <= 1'b1;
        if (inc_w > max_q) begin
          max_q <= inc_w;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      rd_q     <= mem[rd_addr_w];
      rdv_q    <= vld_q[rd_addr_w];
      op_q     <= req_i.command;
      inside_q <= in_range_w;
      idx_q    <= rd_addr_w;
    end
    if (cmd_i.update && inside_q) begin
      mem[idx_q] <= inc_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      count_q <= cur_w;
      prod_q  <= chsb_pkg::PROD_W'(cur_w) * chsb_pkg::PROD_W'(scale_q);
    end
    if (cmd_i.div_init) begin
      rem_q <= prod_q[chsb_pkg::PROD_W-1:BW];
      lo_q  <= prod_q[BW-1:0];
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      lo_q  <= {lo_q[BW-2:0], 1'b0};
      quo_q <= {quo_q[BW-2:0], ge_w};
    end
  end

  assign sts_o.is_query = (op_q == chsb_pkg::CMD_QUERY);

  assign valid_o             = valid_q;
  assign rsp_o.bin_count     = chsb_pkg::to_field(count_q);
  assign rsp_o.bar_length    = quo_q;
  assign rsp_o.largest_count = chsb_pkg::to_field(max_q);

  `CHSB_ASSERT_NOW(a_max_nonzero, 1'b1, max_q != '0, "running max reached zero")
  `CHSB_ASSERT_NOW(a_count_le_max, valid_q, count_q <= max_q, "bin count above running max")
  `CHSB_ASSERT_NOW(a_bar_le_scale, valid_q, {1'b0, quo_q} <= (BW + 1)'(scale_q), "bar above scale")
  `CHSB_ASSERT_NEXT(a_div_query, cmd_i.div_init, op_q == chsb_pkg::CMD_QUERY, "divide on add")

endmodule

// ===== hdl/char_histogram_scaled_bars.sv =====
// top level: byte value histogram with running max and scaled bar lengths
//
//  channel   | handshake               | payload                                   | dir
//  ----------+-------------------------+-------------------------------------------+----
//  request   | start / busy            | req_i  : command, code                    | in
//  result    | result_valid_o (strobe) | rsp_o  : bin_count, bar_length, largest   | out
//  config    | cfg_we_i                | cfg_wdata_i : bar_scale                   | in
//
// a request is taken on a clock edge with start high and busy low
// add request: registered bin read, then increment and write back, no result
// query request: bin read, multiply, divider load, 8 restoring divide steps;
//   the result strobe is high for the one cycle after the last divide step
// a new request may be taken in the same cycle the result strobe is high
// reset clears all bin valid flags at once, the running max to one and bar_scale to 20
module char_histogram_scaled_bars (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  chsb_pkg::req_t               req_i,
  input  logic                         cfg_we_i,
  input  logic [chsb_pkg::SCALE_W-1:0] cfg_wdata_i,
  output logic                         result_valid_o,
  output chsb_pkg::rsp_t               rsp_o
);

  // command and status between the sequencer and the datapath
  chsb_pkg::ctrl_cmd_t cmd;
  chsb_pkg::ctrl_sts_t sts;

  // sequencer: idle, bin read, scale, divide loop
  chsb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  // datapath: bin store with per-bin valid flags, saturating increment,
  // running max, 24x8 multiplier and one-bit-per-cycle divider
  chsb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .valid_o     (result_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule
